>>> sv/bitmap_block_allocator_unit_macros.svh
// Assertion macros shared by the allocator's checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bba_pkg.sv
// Shared types and codes for the bitmap block allocator.
// No dependencies; compiled before the interfaces and modules.
package bba_pkg;

	// Fixed field widths of the request and result words
	localparam int OP_W      = 2;
	localparam int IDX_OUT_W = 8;
	localparam int STATUS_W  = 2;
	localparam int CNT_OUT_W = 7;
	// Counts are worked in this width before masking to the field
	localparam int CNT_EXT_W = 9;

	// First-free search works in groups of this many blocks
	localparam int GRP_SZ   = 16;
	localparam int GRP_SZ_W = 4;

	// Request op codes
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTUSED = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture the request word
		logic commit;  // apply the update and register the result word
	} bba_cmd_t;

endpackage

>>> sv/bba_req_if.sv
// Request channel: valid/ready handshake with op and block index.
// Depends on bba_pkg for field widths.
interface bba_req_if;
	import bba_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [IDX_OUT_W-1:0] block_index;

	modport source (output valid, output op, output block_index, input ready);
	modport sink   (input valid, input op, input block_index, output ready);
endinterface

>>> sv/bba_rsp_if.sv
// Result channel: valid/ready handshake with status, index and counts.
// Depends on bba_pkg for field widths.
interface bba_rsp_if;
	import bba_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [IDX_OUT_W-1:0] result_index;
	logic [CNT_OUT_W-1:0] used_count;
	logic [CNT_OUT_W-1:0] free_count;

	modport source (output valid, output status, output result_index,
		output used_count, output free_count, input ready);
	modport sink   (input valid, input status, input result_index,
		input used_count, input free_count, output ready);
endinterface

>>> sv/bba_ctrl.sv
// Allocator controller: sequences accept, search and commit, owns the
// result valid flag. Depends on bba_pkg for the command struct.
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bba_pkg::bba_cmd_t cmd
);
	import bba_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   slot_free;
	logic   commit;
	logic   accept;

	// Result register can take a word when empty or being drained
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign commit    = (state_q == S_EXEC) && slot_free;
	assign req_ready = (state_q == S_IDLE) || commit;
	assign accept    = req_valid && req_ready;

	assign cmd.load   = accept;
	assign cmd.commit = commit;
	assign rsp_valid  = rsp_valid_q;

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (commit) state_q <= accept ? S_SEARCH : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end
endmodule

>>> sv/bba_datapath.sv
// Allocator datapath: used map, two-level first-free search, used count
// and result word register. Depends on bba_pkg.
module bba_datapath #(
	parameter int NUM_BLOCKS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bba_pkg::bba_cmd_t             cmd,
	input  logic [bba_pkg::OP_W-1:0]      op,
	input  logic [bba_pkg::IDX_OUT_W-1:0] block_index,
	output logic [bba_pkg::STATUS_W-1:0]  status,
	output logic [bba_pkg::IDX_OUT_W-1:0] result_index,
	output logic [bba_pkg::CNT_OUT_W-1:0] used_count,
	output logic [bba_pkg::CNT_OUT_W-1:0] free_count
);
	import bba_pkg::*;

	localparam int IDX_W     = $clog2(NUM_BLOCKS);
	localparam int MAP_IDX_W = (IDX_W > GRP_SZ_W + 1) ? IDX_W : GRP_SZ_W + 1;
	localparam int MAP_W     = 1 << MAP_IDX_W;
	localparam int GRP_W     = MAP_IDX_W - GRP_SZ_W;
	localparam int NUM_GRP   = 1 << GRP_W;
	localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
	localparam logic [CNT_EXT_W-1:0] NB_EXT = CNT_EXT_W'(NUM_BLOCKS);

	// Request word
	logic [OP_W-1:0]      op_q;
	logic [IDX_OUT_W-1:0] idx_q;

	// Map state and count
	logic [MAP_W-1:0] map_q;
	logic [MAP_W-1:0] eff_map;
	logic [CNT_W-1:0] used_q;

	// Search stage
	logic [NUM_GRP-1:0]                 grp_any;
	logic [GRP_SZ_W-1:0]                grp_off [NUM_GRP];
	logic [NUM_GRP-1:0]                 grp_any_s1;
	logic [GRP_SZ_W-1:0]                grp_off_s1 [NUM_GRP];

	// Commit logic
	logic                 found;
	logic [GRP_W-1:0]     found_grp;
	logic [MAP_IDX_W-1:0] alloc_idx;
	logic [MAP_IDX_W-1:0] named_idx;
	logic                 in_range;
	logic                 cur_bit;
	logic [STATUS_W-1:0]  st_d;
	logic [IDX_OUT_W-1:0] res_idx_d;
	logic                 wr_en;
	logic                 wr_val;
	logic [MAP_IDX_W-1:0] wr_idx;
	logic [CNT_W-1:0]     used_d;
	logic [CNT_EXT_W-1:0] used_ext;
	logic [CNT_EXT_W-1:0] free_ext;

	// Blocks past the end read as used so they are never handed out
	for (genvar i = 0; i < MAP_W; i++) begin : g_eff
		if (i < NUM_BLOCKS) begin : g_real
			assign eff_map[i] = map_q[i];
		end else begin : g_pad
			assign eff_map[i] = 1'b1;
		end
	end

	// Lowest free block within each group
	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			grp_any[g] = 1'b0;
			grp_off[g] = '0;
			for (int b = GRP_SZ - 1; b >= 0; b--) begin
				if (!eff_map[g*GRP_SZ + b]) begin
					grp_any[g] = 1'b1;
					grp_off[g] = GRP_SZ_W'(b);
				end
			end
		end
	end

	// Group summaries, registered every cycle
	always_ff @(posedge clk) begin
		grp_any_s1 <= grp_any;
		for (int g = 0; g < NUM_GRP; g++) begin
			grp_off_s1[g] <= grp_off[g];
		end
	end

	// Lowest group holding a free block
	always_comb begin
		found_grp = '0;
		for (int g = NUM_GRP - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) found_grp = GRP_W'(g);
		end
	end

	assign found     = |grp_any_s1;
	assign alloc_idx = {found_grp, grp_off_s1[found_grp]};
	assign named_idx = idx_q[MAP_IDX_W-1:0];
	assign in_range  = CNT_EXT_W'(idx_q) < NB_EXT;
	assign cur_bit   = eff_map[named_idx];

	// Decode the request into result and map update
	always_comb begin
		st_d      = ST_OK;
		res_idx_d = idx_q;
		wr_en     = 1'b0;
		wr_val    = 1'b0;
		wr_idx    = named_idx;
		used_d    = used_q;
		case (op_q)
			OP_ALLOC: begin
				if (found) begin
					res_idx_d = IDX_OUT_W'(alloc_idx);
					wr_en     = 1'b1;
					wr_val    = 1'b1;
					wr_idx    = alloc_idx;
					used_d    = used_q + CNT_W'(1);
				end else begin
					st_d      = ST_FULL;
					res_idx_d = '0;
				end
			end
			OP_FREE: begin
				if (!in_range) begin
					st_d = ST_RANGE;
				end else if (cur_bit) begin
					wr_en  = 1'b1;
					used_d = used_q - CNT_W'(1);
				end else begin
					st_d = ST_NOTUSED;
				end
			end
			default: begin
				// query, and the unassigned code acts as a query
				if (!in_range) begin
					st_d = ST_RANGE;
				end else if (!cur_bit) begin
					st_d = ST_NOTUSED;
				end
			end
		endcase
	end

	assign used_ext = CNT_EXT_W'(used_d);
	assign free_ext = NB_EXT - used_ext;

	// Request capture and result word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			idx_q <= block_index;
		end
		if (cmd.commit) begin
			status       <= st_d;
			result_index <= res_idx_d;
			used_count   <= used_ext[CNT_OUT_W-1:0];
			free_count   <= free_ext[CNT_OUT_W-1:0];
		end
	end

	// Map and used count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q  <= '0;
			used_q <= '0;
		end else if (cmd.commit) begin
			if (wr_en) map_q[wr_idx] <= wr_val;
			used_q <= used_d;
		end
	end
endmodule

>>> sv/bitmap_block_allocator_unit.sv
// First-fit block allocator over NUM_BLOCKS used/free bits, all free after
// reset. Each request (allocate lowest free, free named, query named) gives
// one result word with status, index and the used/free counts after it.
// A request passes a search state, which registers a lowest-free summary
// of every 16-block group, then an exec state, which picks the lowest
// group, updates the map and loads the result register. A new request is
// taken in the commit cycle, so requests run back to back while results are
// drained; a held result stalls the commit. Counts are reported modulo 128.
module bitmap_block_allocator_unit #(
	parameter int NUM_BLOCKS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	bba_req_if.sink   req,
	bba_rsp_if.source rsp
);
	import bba_pkg::*;

	bba_cmd_t cmd;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	bba_datapath #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (req.op),
		.block_index  (req.block_index),
		.status       (rsp.status),
		.result_index (rsp.result_index),
		.used_count   (rsp.used_count),
		.free_count   (rsp.free_count)
	);
endmodule

>>> sv/bba_checker.sv
// Port-level checks for the allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator_unit_macros.svh.
`include "bitmap_block_allocator_unit_macros.svh"

module bba_checker #(
	parameter int NUM_BLOCKS = 64
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [bba_pkg::STATUS_W-1:0]  rsp_status,
	input logic [bba_pkg::IDX_OUT_W-1:0] rsp_result_index,
	input logic [bba_pkg::CNT_OUT_W-1:0] rsp_used_count,
	input logic [bba_pkg::CNT_OUT_W-1:0] rsp_free_count
);
	import bba_pkg::*;

	// Stalled result word holds
	`BBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_result_index) && $stable(rsp_used_count) && $stable(rsp_free_count), "result word changed while stalled")

	// One request at a time: no accept right after an accept
	`BBA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while one is in search")

	// Counts add up to the block total, modulo 128, whenever a result is valid
	`BBA_ASSERT_NOW(a_count_sum, rsp_valid, CNT_OUT_W'(rsp_used_count + rsp_free_count) == CNT_OUT_W'(NUM_BLOCKS), "used and free counts do not sum to block total")

	// Full map reports index zero and no free block
	`BBA_ASSERT_NOW(a_full, rsp_valid && (rsp_status == ST_FULL), (rsp_result_index == '0) && (rsp_free_count == '0), "full result with index or free count set")

	// Range error only for an index past the end
	`BBA_ASSERT_NOW(a_range, rsp_valid && (rsp_status == ST_RANGE), CNT_EXT_W'(rsp_result_index) >= CNT_EXT_W'(NUM_BLOCKS), "range error on an index inside the map")
endmodule

bind bitmap_block_allocator_unit bba_checker #(
	.NUM_BLOCKS (NUM_BLOCKS)
) u_bba_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_result_index (rsp.result_index),
	.rsp_used_count   (rsp.used_count),
	.rsp_free_count   (rsp.free_count)
);
